// ===== design/hkmeq_pkg.sv =====
package hkmeq_pkg;

  // Function codes on the func input.
  localparam logic [1:0] FUNC_KEY = 2'd0;
  localparam logic [1:0] FUNC_REG = 2'd1;
  localparam logic [1:0] FUNC_POP = 2'd2;

  // Codes on the result_kind output.
  localparam logic [1:0] RK_TRIGGER = 2'd0;
  localparam logic [1:0] RK_POP     = 2'd1;
  localparam logic [1:0] RK_REG     = 2'd2;

  // Depth of the command queue between the front and back parts.
  localparam int CQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_REG,
    CMD_POP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] mods;
    logic [7:0] key;
    logic [7:0] action;
  } cmd_t;

  // One hotkey table entry or one queued hotkey event.
  typedef struct packed {
    logic [7:0] mods;
    logic [7:0] key;
    logic [7:0] action;
  } entry_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       event_kind;
    logic [7:0] key;
    logic [7:0] mods;
    logic [7:0] action;
    logic       ok;
  } result_t;

endpackage

// ===== design/hotkey_match_event_queue_core.sv =====
// A register command or a pop of an empty ring gets its result straight from the idle state, a pop
// of an event first reads the ring, and a key event scans 1 to TABLE_ENTRIES table entries.
// Throughput is set by the back part's table scan, one entry per cycle, and by its single
// result register: a new item starts only once the previous result has been taken.
// Reset clears the pointers, the fill count and all valid flags; table and ring contents
// are left as they are and are never read before they are written.
module hotkey_match_event_queue_core #(
  parameter int TABLE_ENTRIES = 16,
  parameter int QUEUE_SLOTS   = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func,
  input  logic [7:0] modifiers,
  input  logic [7:0] key,
  input  logic [7:0] action_id,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] result_kind,
  output logic       event_kind,
  output logic [7:0] out_key,
  output logic [7:0] out_modifiers,
  output logic [7:0] out_action,
  output logic       ok
);
  import hkmeq_pkg::*;

  // The front part registers each accepted item and drops those that can never have an
  // effect: key events with no modifiers and the unused function code.
  logic    st_valid;
  cmd_t    st_cmd;
  logic    cq_full;

  // The command queue lets the front keep taking items while the back is busy scanning
  // the table or holding a result that has not been popped yet.
  logic    cq_valid;
  cmd_t    cq_cmd;
  logic    cq_take;

  logic    res_valid;
  result_t res;

  hkmeq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .modifiers (modifiers),
    .key       (key),
    .action_id (action_id),
    .cmd_valid (st_valid),
    .cmd       (st_cmd),
    .cmd_full  (cq_full)
  );

  hkmeq_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid),
    .in_cmd    (st_cmd),
    .in_full   (cq_full),
    .out_valid (cq_valid),
    .out_cmd   (cq_cmd),
    .out_take  (cq_take)
  );

  // The back part owns the hotkey table and the event ring. It takes a command only from
  // its idle state and only while its result register is free, so each item's effects
  // are complete before the next one starts and results leave in item order.
  hkmeq_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .QUEUE_SLOTS   (QUEUE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cq_valid),
    .cmd       (cq_cmd),
    .cmd_take  (cq_take),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty         = !res_valid;
  assign result_kind   = res.kind;
  assign event_kind    = res.event_kind;
  assign out_key       = res.key;
  assign out_modifiers = res.mods;
  assign out_action    = res.action;
  assign ok            = res.ok;

  // A popped result is never replaced in the same cycle; the register reads empty in the cycle after the pop.
  a_pop_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> empty)
    else $error("result register refilled in the cycle it was popped");

  // Back pressure to the user only comes from a full command queue.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    full |-> (cq_full && st_valid))
    else $error("full raised while the command queue has room");

  // Pops never report success, and register status carries no event.
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result_kind == RK_POP)) |-> !ok)
    else $error("pop result reported ok");

  a_reg_no_event: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result_kind == RK_REG)) |-> !event_kind)
    else $error("register status carries an event");

  // The back takes a command only while its result register is free.
  a_take_free: assert property (@(posedge clk) disable iff (rst)
    cq_take |-> (empty && cq_valid))
    else $error("command taken while a result is still waiting");

endmodule

// ===== design/hkmeq_front.sv =====
module hkmeq_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      func,
  input  logic [7:0]      modifiers,
  input  logic [7:0]      key,
  input  logic [7:0]      action_id,
  output logic            cmd_valid,
  output hkmeq_pkg::cmd_t cmd,
  input  logic            cmd_full
);
  import hkmeq_pkg::*;

  logic stage_valid;
  cmd_t stage;
  cmd_t decoded;
  logic keep;

  // Items that can never produce a result or change state are dropped here.
  always_comb begin
    decoded.mods   = modifiers;
    decoded.key    = key;
    decoded.action = action_id;
    decoded.kind   = CMD_KEY;
    keep           = 1'b0;
    unique case (func)
      FUNC_KEY: begin
        decoded.kind = CMD_KEY;
        keep         = (modifiers != 8'd0);
      end
      FUNC_REG: begin
        decoded.kind = CMD_REG;
        keep         = 1'b1;
      end
      FUNC_POP: begin
        decoded.kind = CMD_POP;
        keep         = 1'b1;
      end
      default: begin
        decoded.kind = CMD_KEY;
        keep         = 1'b0;
      end
    endcase
  end

  assign full      = stage_valid & cmd_full;
  assign cmd_valid = stage_valid;
  assign cmd       = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (push && !full) begin
      stage_valid <= keep;
    end else if (stage_valid && !cmd_full) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      stage <= decoded;
    end
  end

endmodule

// ===== design/hkmeq_cmd_fifo.sv =====
module hkmeq_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  hkmeq_pkg::cmd_t in_cmd,
  output logic            in_full,
  output logic            out_valid,
  output hkmeq_pkg::cmd_t out_cmd,
  input  logic            out_take
);
  import hkmeq_pkg::*;

  localparam int PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CQ_DEPTH + 1);

  cmd_t             slots [CQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign in_full   = (count == CNT_W'(CQ_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = slots[rd_ptr];
  assign do_push   = in_valid && !in_full;
  assign do_pop    = out_take && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ===== design/hkmeq_back.sv =====
module hkmeq_back #(
  parameter int TABLE_ENTRIES = 16,
  parameter int QUEUE_SLOTS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  hkmeq_pkg::cmd_t    cmd,
  output logic               cmd_take,
  output logic               res_valid,
  output hkmeq_pkg::result_t res,
  input  logic               res_pop
);
  import hkmeq_pkg::*;

  localparam int TIW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int PW  = $clog2(QUEUE_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POPRD
  } state_t;

  state_t        state;
  logic [CW-1:0] entry_count;
  logic [TIW-1:0] cmp_idx;
  logic [TIW:0]  cmp_idx_inc;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_next;
  logic [PW-1:0] rd_next;
  logic [7:0]    srch_key;
  logic [7:0]    srch_mods;

  entry_t        tbl_mem [TABLE_ENTRIES];
  entry_t        tbl_q;
  entry_t        ring_mem [QUEUE_SLOTS];
  entry_t        ring_q;

  logic          idle_go;
  logic          room;
  logic          tbl_we;
  logic [TIW-1:0] tbl_raddr;
  logic          hit;
  logic          last;
  logic          ring_full;
  logic          ring_empty;
  logic          ring_we;

  always_comb begin
    wr_next     = (wr_ptr == PW'(QUEUE_SLOTS - 1)) ? '0 : wr_ptr + 1'b1;
    rd_next     = (rd_ptr == PW'(QUEUE_SLOTS - 1)) ? '0 : rd_ptr + 1'b1;
    ring_full   = (wr_next == rd_ptr);
    ring_empty  = (wr_ptr == rd_ptr);
    idle_go     = (state == S_IDLE) && cmd_valid && !res_valid;
    room        = (entry_count < CW'(TABLE_ENTRIES));
    tbl_we      = idle_go && (cmd.kind == CMD_REG) && room;
    cmp_idx_inc = {1'b0, cmp_idx} + 1'b1;
    last        = (cmp_idx_inc == (TIW + 1)'(entry_count));
    tbl_raddr   = (state == S_SCAN) ? cmp_idx_inc[TIW-1:0] : '0;
    hit         = (tbl_q.key == srch_key) && (tbl_q.mods == srch_mods);
    ring_we     = (state == S_SCAN) && hit && !ring_full;
  end

  assign cmd_take = idle_go;

  // Hotkey table: appended at the fill count, scanned one entry per cycle.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[entry_count[TIW-1:0]] <= '{mods: cmd.mods, key: cmd.key, action: cmd.action};
    end
    tbl_q <= tbl_mem[tbl_raddr];
  end

  // Event ring: written at the write pointer, read at the read pointer.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_ptr] <= '{mods: srch_mods, key: srch_key, action: tbl_q.action};
    end
    ring_q <= ring_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      cmp_idx     <= '0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (idle_go) begin
            unique case (cmd.kind)
              CMD_REG: begin
                res_valid <= 1'b1;
                res       <= '{kind: RK_REG, event_kind: 1'b0, key: 8'd0, mods: 8'd0,
                               action: 8'd0, ok: room};
                if (room) begin
                  entry_count <= entry_count + 1'b1;
                end
              end
              CMD_POP: begin
                if (ring_empty) begin
                  res_valid <= 1'b1;
                  res       <= '{kind: RK_POP, event_kind: 1'b0, key: 8'd0, mods: 8'd0,
                                 action: 8'd0, ok: 1'b0};
                end else begin
                  rd_ptr <= rd_next;
                  state  <= S_POPRD;
                end
              end
              CMD_KEY: begin
                if (entry_count != '0) begin
                  srch_key  <= cmd.key;
                  srch_mods <= cmd.mods;
                  cmp_idx   <= '0;
                  state     <= S_SCAN;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_valid <= 1'b1;
            res       <= '{kind: RK_TRIGGER, event_kind: 1'b1, key: srch_key,
                           mods: srch_mods, action: tbl_q.action, ok: !ring_full};
            if (!ring_full) begin
              wr_ptr <= wr_next;
            end
            state <= S_IDLE;
          end else if (last) begin
            state <= S_IDLE;
          end else begin
            cmp_idx <= cmp_idx_inc[TIW-1:0];
          end
        end
        S_POPRD: begin
          res_valid <= 1'b1;
          res       <= '{kind: RK_POP, event_kind: 1'b1, key: ring_q.key, mods: ring_q.mods,
                         action: ring_q.action, ok: 1'b0};
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
